// ----- hw/rtl/cfbe_pkg.sv -----
// cfbe_pkg: shared widths, register indexes, action codes and the
// controller/datapath command and status types of the pixel engine
// depends on nothing
package cfbe_pkg;

  // surface limits and frame store geometry
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int ACT_W   = 2;
  localparam int POS_W   = 13;
  localparam int LEN_W   = 13;
  localparam int PIX_W   = 32;
  localparam int ALPHA_W = 8;
  localparam int CNT_W   = 15;
  localparam int DIM_W   = 8;   // surface size register
  localparam int CPOS_W  = 12;  // normalized clip edge, 0..4095
  localparam int SPAN_W  = 14;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 14;
  localparam int COORD_W = 7;   // in-surface coordinate

  // stream packing
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 48;
  localparam int OFS_PX     = 0;
  localparam int OFS_PY     = OFS_PX + POS_W;
  localparam int OFS_RW     = OFS_PY + POS_W;
  localparam int OFS_RH     = OFS_RW + LEN_W;
  localparam int OFS_PIX    = OFS_RH + LEN_W;
  localparam int OFS_ALPHA  = OFS_PIX + PIX_W;
  localparam int IN_USED_W  = OFS_ALPHA + ALPHA_W;
  localparam int OUT_USED_W = PIX_W + CNT_W;

  // divide by 255 through reciprocal: floor(v * RECIP_255 >> RECIP_SHIFT)
  // exact for every blend sum (at most 255*255 + 127)
  localparam logic [16:0] RECIP_255   = 17'd32897;
  localparam int          RECIP_SHIFT = 23;
  localparam logic [15:0] ROUND_HALF  = 16'd127;
  localparam logic [7:0]  CHAN_MAX    = 8'hFF;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SURF_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_L   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_T   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_SX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_SY  = 3'd5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_FILL  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_COPY  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_BLEND = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

  // normalized clip window and effective surface size
  typedef struct packed {
    logic [DIM_W-1:0]  sw;
    logic [DIM_W-1:0]  sh;
    logic [CPOS_W-1:0] cx;
    logic [DIM_W-1:0]  cw;
    logic [CPOS_W-1:0] cy;
    logic [DIM_W-1:0]  ch;
  } clip_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLIP,
    DP_ADDR,
    DP_CLEAR,
    DP_FILL,
    DP_COPY,
    DP_READ,
    DP_MUL,
    DP_DIV,
    DP_BWR,
    DP_CAP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             fill_ok;
    logic             copy_ok;
    logic             blend_ok;
    logic             in_surf;
    logic             fill_last;
    logic             clr_last;
  } dp_stat_t;

endpackage

// ----- hw/rtl/cfbe_cfg.sv -----
// cfbe_cfg: configuration registers and registered clip normalization
// depends on cfbe_pkg
module cfbe_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cfbe_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [cfbe_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output cfbe_pkg::clip_t                 clip
);
  import cfbe_pkg::*;

  typedef struct packed {
    logic [CPOS_W-1:0] pos;
    logic [DIM_W-1:0]  span;
  } norm_t;

  logic [DIM_W-1:0]         sw_r, sh_r;
  logic signed [POS_W-1:0]  cl_r, ct_r;
  logic signed [SPAN_W-1:0] csx_r, csy_r;
  logic [DIM_W-1:0]         sw_eff, sh_eff;
  norm_t                    nx, ny;
  clip_t                    clip_r, clip_nxt;

  // cut a negative edge to 0, end the span at the surface edge, no negative span
  function automatic norm_t axis_norm(input logic signed [POS_W-1:0] pos,
                                      input logic signed [SPAN_W-1:0] span,
                                      input logic [DIM_W-1:0] lim);
    logic signed [15:0] p;
    logic signed [15:0] s;
    logic signed [15:0] l;
    norm_t r;
    p = {{(16-POS_W){pos[POS_W-1]}}, pos};
    s = {{(16-SPAN_W){span[SPAN_W-1]}}, span};
    l = {{(16-DIM_W){1'b0}}, lim};
    if (p < 0) begin
      s = s + p;
      p = '0;
    end
    if (p + s > l) s = l - p;
    if (s < 0) s = '0;
    r.pos  = p[CPOS_W-1:0];
    r.span = s[DIM_W-1:0];
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r  <= DIM_W'(MAX_WIDTH);
      sh_r  <= DIM_W'(MAX_HEIGHT);
      cl_r  <= '0;
      ct_r  <= '0;
      csx_r <= SPAN_W'(MAX_WIDTH);
      csy_r <= SPAN_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SURF_W:  sw_r  <= cfg_wdata[DIM_W-1:0];
        REG_SURF_H:  sh_r  <= cfg_wdata[DIM_W-1:0];
        REG_CLIP_L:  cl_r  <= cfg_wdata[POS_W-1:0];
        REG_CLIP_T:  ct_r  <= cfg_wdata[POS_W-1:0];
        REG_CLIP_SX: csx_r <= cfg_wdata[SPAN_W-1:0];
        REG_CLIP_SY: csy_r <= cfg_wdata[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  // oversized surface saturates
  assign sw_eff = (sw_r > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : sw_r;
  assign sh_eff = (sh_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : sh_r;

  always_comb begin
    nx = axis_norm(cl_r, csx_r, sw_eff);
    ny = axis_norm(ct_r, csy_r, sh_eff);
    clip_nxt.sw = sw_eff;
    clip_nxt.sh = sh_eff;
    clip_nxt.cx = nx.pos;
    clip_nxt.cw = nx.span;
    clip_nxt.cy = ny.pos;
    clip_nxt.ch = ny.span;
  end

  always_ff @(posedge clk) begin
    clip_r <= clip_nxt;
  end

  assign clip = clip_r;

endmodule

// ----- hw/rtl/cfbe_dp.sv -----
// cfbe_dp: datapath with item registers, clipping, address generation,
// frame store, blend arithmetic and the result register
// depends on cfbe_pkg
module cfbe_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cfbe_pkg::dp_cmd_t                 cmd,
  input  cfbe_pkg::clip_t                   clip,
  input  logic [cfbe_pkg::ACT_W-1:0]        in_act,
  input  logic [cfbe_pkg::IN_DATA_W-1:0]    in_data,
  output cfbe_pkg::dp_stat_t                stat,
  output logic [cfbe_pkg::OUT_DATA_W-1:0]   out_data
);
  import cfbe_pkg::*;

  // item fields
  logic [ACT_W-1:0]         act_r;
  logic signed [POS_W-1:0]  px_r, py_r;
  logic [LEN_W-1:0]         rw_r, rh_r;
  logic [PIX_W-1:0]         pix_r;
  logic [ALPHA_W-1:0]       alpha_r;

  // clip results
  logic                     fill_ok_r, copy_ok_r, blend_ok_r, in_surf_r;
  logic [COORD_W-1:0]       fx0_r, fy0_r, ptx_r, pty_r;
  logic [DIM_W-1:0]         fw_r, fh_r;

  // address generation
  logic [ADDR_W-1:0]        pt_addr_r, row_base_r;
  logic [DIM_W-1:0]         col_r, row_r;
  logic [ADDR_W-1:0]        clr_addr_r;
  logic                     col_end, fill_last;

  // frame store
  logic [PIX_W-1:0]         mem_r [STORE_DEPTH];
  logic [PIX_W-1:0]         rdata_r;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [PIX_W-1:0]         mem_wdata;

  // blend
  logic [15:0]              sum_r [3];
  logic [7:0]               mix_r [3];
  logic [7:0]               alpha_inv;

  // result
  logic [PIX_W-1:0]         rd_r, out_rd_r;
  logic [CNT_W-1:0]         cnt_r, out_cnt_r;

  // clip stage wires
  logic signed [15:0] xs, ys, cxs, cys, cxe, cye, x0, y0, xe, ye, fw, fh;
  logic signed [15:0] sws, shs;

  always_comb begin
    xs  = {{(16-POS_W){px_r[POS_W-1]}}, px_r};
    ys  = {{(16-POS_W){py_r[POS_W-1]}}, py_r};
    cxs = {{(16-CPOS_W){1'b0}}, clip.cx};
    cys = {{(16-CPOS_W){1'b0}}, clip.cy};
    cxe = cxs + {{(16-DIM_W){1'b0}}, clip.cw};
    cye = cys + {{(16-DIM_W){1'b0}}, clip.ch};
    sws = {{(16-DIM_W){1'b0}}, clip.sw};
    shs = {{(16-DIM_W){1'b0}}, clip.sh};
    x0  = (xs > cxs) ? xs : cxs;
    y0  = (ys > cys) ? ys : cys;
    xe  = xs + {{(16-LEN_W){1'b0}}, rw_r};
    ye  = ys + {{(16-LEN_W){1'b0}}, rh_r};
    if (xe > cxe) xe = cxe;
    if (ye > cye) ye = cye;
    fw  = xe - x0;
    fh  = ye - y0;
  end

  assign alpha_inv = CHAN_MAX - alpha_r;
  assign col_end   = (col_r == fw_r - 1'b1);
  assign fill_last = col_end && (row_r == fh_r - 1'b1);

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        act_r   <= in_act;
        px_r    <= in_data[OFS_PX +: POS_W];
        py_r    <= in_data[OFS_PY +: POS_W];
        rw_r    <= in_data[OFS_RW +: LEN_W];
        rh_r    <= in_data[OFS_RH +: LEN_W];
        pix_r   <= in_data[OFS_PIX +: PIX_W];
        alpha_r <= in_data[OFS_ALPHA +: ALPHA_W];
        rd_r    <= '0;
        cnt_r   <= '0;
      end
      DP_CLIP: begin
        fill_ok_r  <= (fw > 0) && (fh > 0);
        copy_ok_r  <= (xs >= cxs) && (xs < cxe) && (ys >= cys) && (ys < cye);
        in_surf_r  <= (xs >= 0) && (xs < sws) && (ys >= 0) && (ys < shs);
        blend_ok_r <= (alpha_r != '0) && (xs >= 0) && (xs < sws) &&
                      (ys >= 0) && (ys < shs);
        fx0_r <= x0[COORD_W-1:0];
        fy0_r <= y0[COORD_W-1:0];
        fw_r  <= fw[DIM_W-1:0];
        fh_r  <= fh[DIM_W-1:0];
        ptx_r <= px_r[COORD_W-1:0];
        pty_r <= py_r[COORD_W-1:0];
      end
      DP_ADDR: begin
        pt_addr_r  <= ADDR_W'(pty_r * clip.sw) + ADDR_W'(ptx_r);
        row_base_r <= ADDR_W'(fy0_r * clip.sw) + ADDR_W'(fx0_r);
        col_r      <= '0;
        row_r      <= '0;
      end
      DP_FILL: begin
        cnt_r <= cnt_r + 1'b1;
        if (col_end) begin
          col_r      <= '0;
          row_r      <= row_r + 1'b1;
          row_base_r <= row_base_r + ADDR_W'(clip.sw);
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      DP_COPY: cnt_r <= cnt_r + 1'b1;
      DP_BWR:  cnt_r <= cnt_r + 1'b1;
      DP_CAP:  rd_r  <= rdata_r;
      default: ;
    endcase
  end

  // blend: products summed with rounding, then reciprocal multiply
  always_ff @(posedge clk) begin
    if (cmd.op == DP_MUL) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= 16'(pix_r[8*i +: 8] * alpha_r) +
                    16'(rdata_r[8*i +: 8] * alpha_inv) + ROUND_HALF;
      end
    end
    if (cmd.op == DP_DIV) begin
      for (int i = 0; i < 3; i++) begin
        mix_r[i] <= 8'((33'(sum_r[i]) * 33'(RECIP_255)) >> RECIP_SHIFT);
      end
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.op == DP_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
  end

  // frame store write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pt_addr_r;
    mem_wdata = pix_r;
    case (cmd.op)
      DP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      DP_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = row_base_r + ADDR_W'(col_r);
      end
      DP_COPY: mem_we = 1'b1;
      DP_BWR: begin
        mem_we    = 1'b1;
        mem_wdata = {8'h00, mix_r[2], mix_r[1], mix_r[0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_READ) rdata_r <= mem_r[pt_addr_r];
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rd_r  <= rd_r;
      out_cnt_r <= cnt_r;
    end
  end

  assign out_data = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, out_cnt_r, out_rd_r};

  assign stat.act       = act_r;
  assign stat.fill_ok   = fill_ok_r;
  assign stat.copy_ok   = copy_ok_r;
  assign stat.blend_ok  = blend_ok_r;
  assign stat.in_surf   = in_surf_r;
  assign stat.fill_last = fill_last;
  assign stat.clr_last  = &clr_addr_r;

endmodule

// ----- hw/rtl/cfbe_ctrl.sv -----
// cfbe_ctrl: controller state machine, sequences the datapath per action
// and owns the handshake of both stream sides
// depends on cfbe_pkg
module cfbe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  cfbe_pkg::dp_stat_t  stat,
  output cfbe_pkg::dp_cmd_t   cmd
);
  import cfbe_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CLIP, S_ADDR, S_FILL, S_COPY,
    S_BRD, S_BMUL, S_BDIV, S_BWR, S_RRD, S_RCAP, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = DP_NOP;
    cmd.out_load = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_CLIP;
        end
      end
      S_CLIP: begin
        cmd.op    = DP_CLIP;
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        cmd.op    = DP_ADDR;
        state_nxt = S_DONE;
        case (stat.act)
          ACT_FILL:  if (stat.fill_ok)  state_nxt = S_FILL;
          ACT_COPY:  if (stat.copy_ok)  state_nxt = S_COPY;
          ACT_BLEND: if (stat.blend_ok) state_nxt = S_BRD;
          ACT_READ:  if (stat.in_surf)  state_nxt = S_RRD;
          default: ;
        endcase
      end
      S_FILL: begin
        cmd.op = DP_FILL;
        if (stat.fill_last) state_nxt = S_DONE;
      end
      S_COPY: begin
        cmd.op    = DP_COPY;
        state_nxt = S_DONE;
      end
      S_BRD: begin
        cmd.op    = DP_READ;
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        cmd.op    = DP_MUL;
        state_nxt = S_BDIV;
      end
      S_BDIV: begin
        cmd.op    = DP_DIV;
        state_nxt = S_BWR;
      end
      S_BWR: begin
        cmd.op    = DP_BWR;
        state_nxt = S_DONE;
      end
      S_RRD: begin
        cmd.op    = DP_READ;
        state_nxt = S_RCAP;
      end
      S_RCAP: begin
        cmd.op    = DP_CAP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else                 out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// ----- hw/rtl/clipped_fill_copy_blend_engine.sv -----
// clipped_fill_copy_blend_engine: top level of the 2d pixel engine
// depends on cfbe_pkg, cfbe_cfg, cfbe_ctrl, cfbe_dp
//
//   channel | ports                              | payload
//   --------+------------------------------------+-----------------------------------
//   in      | in_tvalid in_tready in_tdata in_tuser | one action beat
//   out     | out_tvalid out_tready out_tdata   | one result beat per input beat
//   cfg     | cfg_we cfg_addr cfg_wdata         | register write, no read-back
//
// an action that writes nothing steps through load, clip, address and done; copy adds
// a write, read a read and a capture, blend a read, multiply, divide and write,
// fill one write per covered pixel; the frame store has one write port, so fill
// paints one pixel a cycle; reset (rst_n low, synchronous) starts a clearing pass
// that zeroes all 16384 frame store pixels one pixel a cycle, with in_tready low
// a finished result sits in the output register; the next beat is taken
// while it waits, but its own result is held until out_tready frees the slot
module clipped_fill_copy_blend_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: pos_x[12:0] pos_y[25:13] rect_width[38:26] rect_height[51:39]
  //           pixel_value[83:52] blend_alpha[91:84], zero pad up to bit 95
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cfbe_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: action[1:0]
  input  logic [cfbe_pkg::ACT_W-1:0]         in_tuser,
  // out_tdata: read_value[31:0] written_count[46:32], zero pad bit 47
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cfbe_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [cfbe_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [cfbe_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
  import cfbe_pkg::*;

  clip_t    clip;   // normalized clip window and surface size
  dp_cmd_t  cmd;    // controller to datapath
  dp_stat_t stat;   // datapath to controller

  // register file; the normalized clip is registered behind the written registers
  cfbe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .clip      (clip)
  );

  // sequencing and both handshakes
  cfbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // clipping, addressing, frame store, blend and result register
  cfbe_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .clip     (clip),
    .in_act   (in_tuser),
    .in_data  (in_tdata),
    .stat     (stat),
    .out_data (out_tdata)
  );

endmodule

// ----- hw/rtl/cfbe_chk.sv -----
// cfbe_chk: port-level checks for the pixel engine, bound to the top level
// depends on the top-level port list only
module cfbe_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a result that wrote pixels never carries read data
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[46:32] != 15'd0) |-> (out_tdata[31:0] == 32'd0))
    else $error("read value on a writing action");

  // no action covers more than the whole store
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[46:32] <= 15'd16384))
    else $error("written count beyond store size");

  // reset starts the clearing pass: nothing taken, nothing shown
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("engine active right after reset");

  // every beat is worked through before the next is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on back-to-back cycles");

endmodule

bind clipped_fill_copy_blend_engine cfbe_chk u_cfbe_chk (.*);
